/* rtl/cfpf_pkg.sv */
// Shared types and constants for the CAN frame packet framer.
// Used by cfpf_front, cfpf_queue, cfpf_back and can_frame_packet_framer_core.
package cfpf_pkg;

  typedef struct packed {
    logic        first_of_frame;
    logic [28:0] frame_id;
    logic        extended;
    logic        fd_frame;
    logic        bit_rate_switch;
    logic        error_state;
    logic [1:0]  channel;
    logic [6:0]  byte_count;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
  } result_t;

  // One queued command: a whole header (plus first data byte) or a single data byte.
  typedef struct packed {
    logic        is_header;
    logic [7:0]  seq;
    logic [6:0]  n;
    logic [31:0] id_word;
    logic [1:0]  channel;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  localparam logic [7:0] SYNC_BYTE   = 8'hA6;
  localparam logic [7:0] BATCH_FLAGS = 8'h01;
  localparam logic [7:0] FRAME_COUNT = 8'h01;
  localparam int         HDR_LEN     = 23;
  localparam logic [6:0] LEN_BASE    = 7'd17;
  localparam logic [6:0] REC_BASE    = 7'd7;

  function automatic logic [3:0] dlc_code(input logic [6:0] n);
    logic [3:0] code;
    if (n <= 7'd8)       code = n[3:0];
    else if (n <= 7'd12) code = 4'd9;
    else if (n <= 7'd16) code = 4'd10;
    else if (n <= 7'd20) code = 4'd11;
    else if (n <= 7'd24) code = 4'd12;
    else if (n <= 7'd32) code = 4'd13;
    else if (n <= 7'd48) code = 4'd14;
    else                 code = 4'd15;
    return code;
  endfunction

endpackage

/* rtl/cfpf_front.sv */
// Front end: accepts input items, tracks frame state and issues commands.
// Depends on cfpf_pkg.
module cfpf_front #(
  parameter int MAX_DATA_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_stall,
  input  cfpf_pkg::item_t item,
  output logic           push,
  output cfpf_pkg::cmd_t push_cmd
);
  import cfpf_pkg::*;

  logic [7:0] sequence_number;
  logic [6:0] bytes_left;
  logic [6:0] n_sat;
  logic       accept;

  assign accept = item_valid && !item_stall;
  assign n_sat  = (item.byte_count > 7'(MAX_DATA_BYTES)) ? 7'(MAX_DATA_BYTES)
                                                          : item.byte_count;
  assign push   = accept && (item.first_of_frame || (bytes_left != 7'd0));

  always_comb begin
    push_cmd.is_header = item.first_of_frame;
    push_cmd.seq       = sequence_number;
    push_cmd.n         = n_sat;
    push_cmd.id_word   = {3'b000, item.frame_id}
                       | {item.extended, item.fd_frame, item.bit_rate_switch,
                          item.error_state, 28'd0};
    push_cmd.channel   = item.channel;
    push_cmd.data      = item.data_byte;
    push_cmd.last      = (bytes_left == 7'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number <= 8'd0;
      bytes_left      <= 7'd0;
    end else if (accept) begin
      if (item.first_of_frame) begin
        sequence_number <= sequence_number + 8'd1;
        bytes_left      <= (n_sat == 7'd0) ? 7'd0 : n_sat - 7'd1;
      end else if (bytes_left != 7'd0) begin
        bytes_left <= bytes_left - 7'd1;
      end
    end
  end

endmodule

/* rtl/cfpf_queue.sv */
// Four-entry command queue between front and back ends.
// Depends on cfpf_pkg.
module cfpf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cfpf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cfpf_pkg::cmd_t head
);
  import cfpf_pkg::*;

  cmd_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full       = (count == 3'd4);
  assign head_valid = (count != 3'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      case ({push, pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/cfpf_back.sv */
// Back end: expands queued commands into packet bytes behind an output register.
// Depends on cfpf_pkg.
module cfpf_back #(
  parameter int MSG_TYPE     = 32,
  parameter int HEADER_FLAGS = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  cfpf_pkg::cmd_t   head,
  output logic             pop,
  output logic             packet_valid,
  input  logic             packet_stall,
  output cfpf_pkg::result_t packet
);
  import cfpf_pkg::*;

  logic [4:0]  idx;
  logic [4:0]  idx_next;
  logic        load;
  logic [15:0] len;
  logic [15:0] rec;
  logic [7:0]  meta;
  logic [7:0]  hdr_byte;
  result_t     next_res;

  assign load = head_valid && (!packet_valid || !packet_stall);
  assign len  = 16'(LEN_BASE) + 16'(head.n);
  assign rec  = 16'(REC_BASE) + 16'(head.n);
  assign meta = {head.channel, 2'b00, dlc_code(head.n)};

  always_comb begin
    case (idx)
      5'd0:    hdr_byte = SYNC_BYTE;
      5'd1:    hdr_byte = 8'(MSG_TYPE);
      5'd2:    hdr_byte = 8'(HEADER_FLAGS);
      5'd3:    hdr_byte = head.seq;
      5'd4:    hdr_byte = len[7:0];
      5'd5:    hdr_byte = len[15:8];
      5'd6:    hdr_byte = BATCH_FLAGS;
      5'd7:    hdr_byte = FRAME_COUNT;
      5'd14:   hdr_byte = rec[7:0];
      5'd15:   hdr_byte = rec[15:8];
      5'd16:   hdr_byte = head.id_word[7:0];
      5'd17:   hdr_byte = head.id_word[15:8];
      5'd18:   hdr_byte = head.id_word[23:16];
      5'd19:   hdr_byte = head.id_word[31:24];
      5'd20:   hdr_byte = meta;
      5'd23:   hdr_byte = head.data;
      default: hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    next_res.out_byte   = head.data;
    next_res.packet_end = head.last;
    idx_next            = idx;
    pop                 = 1'b0;
    if (head.is_header) begin
      next_res.out_byte   = hdr_byte;
      next_res.packet_end = 1'b0;
      if (idx == 5'(HDR_LEN - 1)) begin
        if (head.n == 7'd0) begin
          next_res.packet_end = 1'b1;
          pop                 = load;
          if (load) idx_next = 5'd0;
        end else if (load) begin
          idx_next = idx + 5'd1;
        end
      end else if (idx == 5'(HDR_LEN)) begin
        next_res.packet_end = (head.n == 7'd1);
        pop                 = load;
        if (load) idx_next = 5'd0;
      end else if (load) begin
        idx_next = idx + 5'd1;
      end
    end else begin
      pop = load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= 5'd0;
      packet_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        packet_valid <= 1'b1;
      end else if (!packet_stall) begin
        packet_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      packet <= next_res;
    end
  end

endmodule

/* rtl/can_frame_packet_framer_core.sv */
// CAN frame packet framer, top level.
// Depends on cfpf_pkg, cfpf_front, cfpf_queue and cfpf_back.
//
// Input channel (item, item_valid, item_stall): one item per cycle while
// item_stall is low. An item with first_of_frame set starts a packet: a 23-byte
// header, then its data byte when the frame carries data. Later items each add
// one data byte; items past the frame's byte count are taken and dropped.
// Output channel (packet, packet_valid, packet_stall): one packet byte per
// cycle while packet_stall is low; packet_end marks the final byte of a packet.
// The first byte of an item passes through the command queue and then the
// single output register; a frame start yields 23 or 24 output bytes, while
// each data item yields one output byte.
// A four-entry command queue sits between input and output; item_stall rises
// only when it is full, so a stalled output backs up into the input after the
// queue fills. The output byte holds while packet_stall is high.
// Reset clears the sequence number, the frame state, the queue and the output.
module can_frame_packet_framer_core #(
  parameter int MAX_DATA_BYTES = 64,
  parameter int MSG_TYPE       = 32,
  parameter int HEADER_FLAGS   = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cfpf_pkg::item_t   item,
  output logic              packet_valid,
  input  logic              packet_stall,
  output cfpf_pkg::result_t packet
);
  import cfpf_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t head;

  assign item_stall = full;

  cfpf_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  cfpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  cfpf_back #(
    .MSG_TYPE    (MSG_TYPE),
    .HEADER_FLAGS(HEADER_FLAGS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .packet_valid(packet_valid),
    .packet_stall(packet_stall),
    .packet      (packet)
  );

endmodule
